// File: rtl/kdfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed dual FNV-1a quote package
// Shared constants, queue word and key bundle types, and the mixing helpers.
// ----------------------------------------------------------------------------
package kdfq_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] MIX_MUL_A = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_B = 32'hC2B2_AE35;
    localparam logic [31:0] GOLDEN    = 32'h9E37_79B9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ID_ZERO = 2'd0,
        REG_ID_ONE  = 2'd1,
        REG_ID_TWO  = 2'd2,
        REG_NONCE   = 2'd3
    } cfg_reg_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic       empty;
        logic       start;
        logic       last;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        ready;
    } keys_t;

    function automatic logic [31:0] fold16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] fold13(input logic [31:0] v);
        return v ^ (v >> 13);
    endfunction

    function automatic logic [31:0] fnv_step(input logic [31:0] lane,
                                             input logic [7:0]  b);
        logic [31:0] x;
        x = lane ^ {24'd0, b};
        return 32'(x * FNV_PRIME);
    endfunction

endpackage : kdfq_pkg
`default_nettype wire

// File: rtl/kdfq_keys.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Key derivation
// Holds the ID and nonce registers and runs four fmix32 pipelines that
// produce the lane start values, with a countdown that marks them fresh.
// ----------------------------------------------------------------------------
module kdfq_keys
    import kdfq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output keys_t                       keys
);

    localparam logic [1:0] KEY_LATENCY = 2'd3;

    logic [31:0] id0_reg, id1_reg, id2_reg, nonce_reg;
    logic [31:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic [31:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic [31:0] key_lo_reg, key_hi_reg;
    logic [1:0]  stale_reg, stale_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id0_reg   <= '0;
            id1_reg   <= '0;
            id2_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ID_ZERO: id0_reg   <= cfg_data;
                REG_ID_ONE:  id1_reg   <= cfg_data;
                REG_ID_TWO:  id2_reg   <= cfg_data;
                REG_NONCE:   nonce_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Three register stages; the keys follow the ID and nonce registers through the a, b and key registers.
    always_ff @(posedge clk)
    begin
        a0_reg <= 32'(fold16(id0_reg ^ id2_reg) * MIX_MUL_A);
        a1_reg <= 32'(fold16(nonce_reg) * MIX_MUL_A);
        a2_reg <= 32'(fold16(id1_reg ^ GOLDEN) * MIX_MUL_A);
        a3_reg <= 32'(fold16(nonce_reg ^ GOLDEN) * MIX_MUL_A);
        b0_reg <= 32'(fold13(a0_reg) * MIX_MUL_B);
        b1_reg <= 32'(fold13(a1_reg) * MIX_MUL_B);
        b2_reg <= 32'(fold13(a2_reg) * MIX_MUL_B);
        b3_reg <= 32'(fold13(a3_reg) * MIX_MUL_B);
        key_lo_reg <= FNV_BASIS ^ fold16(b0_reg) ^ fold16(b1_reg);
        key_hi_reg <= FNV_BASIS ^ fold16(b2_reg) ^ fold16(b3_reg);
    end

    always_comb
    begin
        if (cfg_write)
            stale_next = KEY_LATENCY;
        else if (stale_reg != 2'd0)
            stale_next = stale_reg - 2'd1;
        else
            stale_next = stale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stale_reg <= KEY_LATENCY;
        else
            stale_reg <= stale_next;
    end

    assign keys.lo    = key_lo_reg;
    assign keys.hi    = key_hi_reg;
    assign keys.ready = (stale_reg == 2'd0);

endmodule : kdfq_keys
`default_nettype wire

// File: rtl/kdfq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts input words and tags each one as empty message, first byte of a
// message or last byte, then hands it to the queue.
// ----------------------------------------------------------------------------
module kdfq_front
    import kdfq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       empty_message,
    input  wire logic       q_full,
    output logic            push,
    output entry_t          push_entry
);

    logic inside_reg, inside_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign push_entry.empty = empty_message;
    assign push_entry.start = !inside_reg;
    assign push_entry.last  = final_byte;
    assign push_entry.data  = data_byte;

    always_comb
    begin
        inside_next = inside_reg;
        if (push)
            inside_next = !(empty_message || final_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else
            inside_reg <= inside_next;
    end

endmodule : kdfq_front
`default_nettype wire

// File: rtl/kdfq_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Word queue
// Short FIFO between the front end and the hashing back end.
// ----------------------------------------------------------------------------
module kdfq_queue
    import kdfq_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  entry_t      push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output entry_t      pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    entry_t            slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule : kdfq_queue
`default_nettype wire

// File: rtl/kdfq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashing back end
// Runs both FNV-1a lanes on queued words, finalizes them with fmix32 over
// two multiply states and holds the quote in an output register.
// ----------------------------------------------------------------------------
module kdfq_back
    import kdfq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  entry_t      q_entry,
    output logic        pop,
    input  keys_t       keys,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [63:0] quote
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_MIX1 = 4'b0010,
        ST_MIX2 = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic [31:0] mix_lo_reg, mix_lo_next;
    logic [31:0] mix_hi_reg, mix_hi_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] quote_reg, quote_next;
    logic        out_free;
    logic [31:0] base_lo, base_hi, lane_lo, lane_hi;

    assign out_free = !out_valid_reg || out_ready;

    // A first byte starts from the keys instead of the running lanes.
    assign base_lo = q_entry.start ? keys.lo : low_reg;
    assign base_hi = q_entry.start ? keys.hi : high_reg;
    assign lane_lo = fnv_step(base_lo, q_entry.data);
    assign lane_hi = fnv_step(base_hi, q_entry.data) ^ lane_lo;

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mix_lo_next    = mix_lo_reg;
        mix_hi_next    = mix_hi_reg;
        quote_next     = quote_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (q_valid)
                begin
                    if (q_entry.empty)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            quote_next     = '0;
                        end
                    end
                    else if (!q_entry.start || keys.ready)
                    begin
                        pop       = 1'b1;
                        low_next  = lane_lo;
                        high_next = lane_hi;
                        if (q_entry.last)
                            state_next = ST_MIX1;
                    end
                end
            end
            ST_MIX1:
            begin
                mix_lo_next = 32'(fold16(low_reg) * MIX_MUL_A);
                mix_hi_next = 32'(fold16(high_reg) * MIX_MUL_A);
                state_next  = ST_MIX2;
            end
            ST_MIX2:
            begin
                mix_lo_next = 32'(fold13(mix_lo_reg) * MIX_MUL_B);
                mix_hi_next = 32'(fold13(mix_hi_reg) * MIX_MUL_B);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    quote_next     = {fold16(mix_hi_reg), fold16(mix_lo_reg)};
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg    <= low_next;
        high_reg   <= high_next;
        mix_lo_reg <= mix_lo_next;
        mix_hi_reg <= mix_hi_next;
        quote_reg  <= quote_next;
    end

    assign out_valid = out_valid_reg;
    assign quote     = quote_reg;

    a_mix_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX2) |-> $past(state_reg == ST_MIX1))
        else $error("second mix stage entered out of order");

    a_pop_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !pop)
        else $error("queue popped while finalizing");

    a_new_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(state_reg == ST_DONE || (pop && q_entry.empty)))
        else $error("result appeared without a final or empty word");

    a_first_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_entry.start && !q_entry.empty) |-> keys.ready)
        else $error("message started on stale keys");

endmodule : kdfq_back
`default_nettype wire

// File: rtl/keyed_dual_fnv1a_quote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed dual FNV-1a quote
// Hashes a byte stream with two keyed FNV-1a lanes into a 64-bit quote.
// Throughput: one byte per cycle inside a message while the queue has room;
// a final byte holds the back end through lane update, two fmix multiply
// states and output. An empty message's zero goes straight to the output
// register. A first byte waits until the key pipeline marks the keys ready
// after any register write. Reset clears the ID and nonce registers to zero
// and resets control state; the keys then count down to ready.
// ----------------------------------------------------------------------------
module keyed_dual_fnv1a_quote
    import kdfq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   final_byte,
    input  wire logic                   empty_message,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [63:0]                 quote
);

    keys_t  keys;
    logic   push, pop, q_full, q_valid;
    entry_t push_entry, pop_entry;

    kdfq_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    kdfq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .empty_message (empty_message),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    kdfq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .pop_entry  (pop_entry)
    );

    kdfq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .pop       (pop),
        .keys      (keys),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quote     (quote)
    );

endmodule : keyed_dual_fnv1a_quote
`default_nettype wire

// File: tb/keyed_dual_fnv1a_quote_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed dual FNV-1a quote testbench
// A short directed table is followed by randomized message phases. Each phase
// uses its own register setting and one of four idling patterns. Every quote
// is checked against a local model of the keyed lanes and the fmix32 finalizer.
// ----------------------------------------------------------------------------
module keyed_dual_fnv1a_quote_tb;
    import kdfq_pkg::*;

    localparam int WORDS_TARGET  = 1750;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    localparam int SEND_IDLE [NUM_PHASES] = '{0, 62, 0, 15, 62, 15};
    localparam int RECV_IDLE [NUM_PHASES] = '{0, 0, 62, 15, 0, 15};

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        empty;
        logic        known;
        logic [63:0] quote;
    } vector_t;

    // The quote is typed in only for empty messages, which always give zero.
    localparam int NUM_VECTORS = 19;
    localparam vector_t VECTORS [NUM_VECTORS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h55, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 64'h0},
        '{8'h12, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h34, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 64'h0}
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte     = '0;
    logic                   final_byte    = 1'b0;
    logic                   empty_message = 1'b0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [63:0]            quote;

    // Local copy of the registers and the lane state.
    logic [31:0] dev_regs [4] = '{default: '0};
    logic [31:0] lane_lo  = '0;
    logic [31:0] lane_hi  = '0;
    bit          msg_open = 1'b0;

    logic [63:0] pending_quotes [$];
    logic [63:0] oldest_quote;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          words_sent    = 0;
    int          quotes_seen   = 0;
    int          mismatches    = 0;

    keyed_dual_fnv1a_quote dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .empty_message (empty_message),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .quote         (quote)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] avalanche(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v >> 16);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 13);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 16);
        return x;
    endfunction

    task automatic predict_quote(input logic [7:0] d, input logic f, input logic e,
                                 output bit got, output logic [63:0] q);
        logic [31:0] key_lo;
        logic [31:0] key_hi;
        got = 1'b0;
        q   = '0;
        if (e) begin
            msg_open = 1'b0;
            got      = 1'b1;
        end
        else begin
            // Keys are taken only on the first byte of a message.
            if (!msg_open) begin
                key_lo  = avalanche(dev_regs[REG_ID_ZERO] ^ dev_regs[REG_ID_TWO])
                        ^ avalanche(dev_regs[REG_NONCE]);
                key_hi  = avalanche(dev_regs[REG_ID_ONE] ^ GOLDEN)
                        ^ avalanche(dev_regs[REG_NONCE] ^ GOLDEN);
                lane_lo = FNV_BASIS ^ key_lo;
                lane_hi = FNV_BASIS ^ key_hi;
            end
            lane_lo = (lane_lo ^ {24'd0, d}) * FNV_PRIME;
            lane_hi = (lane_hi ^ {24'd0, d}) * FNV_PRIME;
            lane_hi = lane_hi ^ lane_lo;
            if (f) begin
                msg_open = 1'b0;
                got      = 1'b1;
                q        = {avalanche(lane_hi), avalanche(lane_lo)};
            end
            else begin
                msg_open = 1'b1;
            end
        end
    endtask

    task automatic drive_word(input logic [7:0] d, input logic f, input logic e);
        bit hold;
        hold = ($urandom_range(99) < send_idle_pct);
        while (hold) begin
            in_valid <= 1'b0;
            @(posedge clk);
            hold = ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        data_byte     <= d;
        final_byte    <= f;
        empty_message <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic issue_word(input logic [7:0] d, input logic f, input logic e);
        bit          got;
        logic [63:0] q;
        drive_word(d, f, e);
        predict_quote(d, f, e, got, q);
        if (got) pending_quotes.push_back(q);
    endtask

    // Stops the sender and waits until every quote is back and the block is quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_quotes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0][31:0] vals);
        cfg_reg_t idx;
        idx = idx.first();
        for (int i = 0; i < idx.num(); i++) begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            dev_regs[idx] = vals[idx];
            idx = idx.next();
        end
        cfg_write <= 1'b0;
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_quotes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: quote %h arrived with none expected", quote);
            end
            else begin
                oldest_quote = pending_quotes.pop_front();
                quotes_seen++;
                if (quote !== oldest_quote) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: quote expected %h got %h", oldest_quote, quote);
                end
            end
        end
    end

    initial begin
        bit               got;
        logic [63:0]      q;
        logic [3:0][31:0] vals;
        int               r;
        int               len;
        int               sent;
        int               quota;

        quota = WORDS_TARGET / NUM_PHASES;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_VECTORS; i++) begin
            drive_word(VECTORS[i].data, VECTORS[i].fin, VECTORS[i].empty);
            predict_quote(VECTORS[i].data, VECTORS[i].fin, VECTORS[i].empty, got, q);
            if (got) pending_quotes.push_back(VECTORS[i].known ? VECTORS[i].quote : q);
        end

        // The table ends inside a message, so the first register write of the
        // random part lands mid-message and must only affect the next one.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            case (phase)
                0:       vals = {4{32'hFFFF_FFFF}};
                1:       vals = '0;
                3:       vals = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
                default: for (int k = 0; k < 4; k++) vals[k] = $urandom;
            endcase
            program_regs(vals);

            sent = 0;
            while (sent < quota) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    issue_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                    sent++;
                end
                else begin
                    len = (r < 16) ? $urandom_range(48, 9) : $urandom_range(8, 1);
                    for (int k = 0; k < len && sent < quota; k++) begin
                        // An empty word now and then breaks the message off.
                        if ($urandom_range(99) < 2) begin
                            issue_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                                       1'b1);
                            sent++;
                        end
                        issue_word(8'($urandom_range(255)), (k == len - 1), 1'b0);
                        sent++;
                    end
                end
            end
        end

        wait_drained();
        $display("Sent %0d words over %0d phases with %0d register settings.",
                 words_sent, NUM_PHASES, NUM_PHASES + 1);
        $display("Checked %0d quotes; %0d mismatches.", quotes_seen, mismatches);
        if (mismatches == 0 && pending_quotes.size() == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("ERROR: timeout with %0d quotes outstanding", pending_quotes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
